// ===== rtl/gated_period_average_meter_unit_assert.svh =====
// Assertion helpers shared by the meter's RTL files.
// Both macros expect clk_i in scope; GPAM_ASSERT also expects rst_ni.
`ifndef GATED_PERIOD_AVERAGE_METER_UNIT_ASSERT_SVH
`define GATED_PERIOD_AVERAGE_METER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define GPAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define GPAM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define GPAM_ASSERT(lbl, prop, msg)
`define GPAM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/gpam_pkg.sv =====
`default_nettype none

package gpam_pkg;

  localparam int unsigned VAL_W    = 8;
  localparam int unsigned OUT_W    = 40;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CAPTURE  = 8'd1;

  localparam logic [VAL_W-1:0] WINDOW_TICKS_RST = 8'd20;
  localparam logic [VAL_W-1:0] MIN_CAPTURE_RST  = 8'd1;
  localparam int unsigned      BASE_COUNT_RST   = 1;
  localparam int unsigned      BASE_SUM_RST     = 50;

  localparam logic FUNC_CAPTURE = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } gpam_state_e;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic load;
  } gpam_cmd_t;

  typedef struct packed {
    logic close;
    logic div_last;
    logic out_free;
  } gpam_sts_t;

endpackage

`default_nettype wire

// ===== rtl/gpam_intf.sv =====
`default_nettype none

interface gpam_evt_if import gpam_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [VAL_W-1:0] capture_value;
  logic             calibrate_request;

  modport source (output valid, func, capture_value, calibrate_request, input ready);
  modport sink   (input valid, func, capture_value, calibrate_request, output ready);
endinterface

interface gpam_res_if import gpam_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] ratio_value;
  logic                    divide_by_zero;

  modport source (output valid, ratio_value, divide_by_zero, input ready);
  modport sink   (input valid, ratio_value, divide_by_zero, output ready);
endinterface

interface gpam_cfg_if import gpam_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [VAL_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/gpam_ctrl.sv =====
`default_nettype none
`include "gated_period_average_meter_unit_assert.svh"

module gpam_ctrl import gpam_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      evt_valid_i,
  output logic           evt_ready_o,
  input  wire gpam_sts_t sts_i,
  output gpam_cmd_t      cmd_o
);

  gpam_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (evt_valid_i && sts_i.close) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    evt_ready_o     = 1'b0;
    cmd_o           = '0;
    unique case (state_q)
      S_IDLE: begin
        evt_ready_o  = 1'b1;
        cmd_o.accept = evt_valid_i;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      S_DONE: begin
        cmd_o.load = sts_i.out_free;
      end
      default: begin
        evt_ready_o = 1'b0;
      end
    endcase
  end

  `GPAM_ASSERT(a_close_starts_div, (cmd_o.accept && sts_i.close) |=> (state_q == S_DIV), "closing word did not start the divider")
  `GPAM_ASSERT(a_div_ends, (state_q == S_DIV && sts_i.div_last) |=> (state_q == S_DONE), "divider did not finish")
  `GPAM_ASSERT(a_no_accept_busy, (state_q != S_IDLE) |-> (!cmd_o.accept && !evt_ready_o), "word taken while busy")

endmodule

`default_nettype wire

// ===== rtl/gpam_dp.sv =====
`default_nettype none
`include "gated_period_average_meter_unit_assert.svh"

module gpam_dp import gpam_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned SUM_WIDTH   = 32,
  parameter int unsigned FRAC_BITS   = 8
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire gpam_cmd_t               cmd_i,
  output gpam_sts_t                    sts_o,
  input  wire logic                    evt_func_i,
  input  wire logic [VAL_W-1:0]        evt_capture_value_i,
  input  wire logic                    evt_calibrate_request_i,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [VAL_W-1:0]        cfg_data_i,
  output logic                         res_valid_o,
  input  wire logic                    res_ready_i,
  output logic signed [OUT_W-1:0]      res_ratio_value_o,
  output logic                         res_divide_by_zero_o
);

  localparam int unsigned CW     = COUNT_WIDTH;
  localparam int unsigned SW     = SUM_WIDTH;
  localparam int unsigned NUM_W  = SUM_WIDTH + FRAC_BITS;
  localparam int unsigned STEP_W = $clog2(NUM_W + 1);
  localparam int unsigned QEXT_W = (NUM_W > OUT_W) ? NUM_W : OUT_W;

  localparam logic [QEXT_W-1:0] POS_MAX = QEXT_W'({1'b0, {(OUT_W-1){1'b1}}});
  localparam logic [QEXT_W-1:0] NEG_MAX = QEXT_W'({1'b1, {(OUT_W-1){1'b0}}});

  logic [VAL_W-1:0]  window_ticks_q, min_capture_q;
  logic [CW-1:0]     count_q, count_d, base_count_q, base_count_d;
  logic [SW-1:0]     sum_q, sum_d, base_sum_q, base_sum_d;
  logic [VAL_W-1:0]  tick_q, tick_d;
  logic [NUM_W-1:0]  num_q, num_d;
  logic [CW-1:0]     den_q, den_d, rem_q, rem_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              neg_q, neg_d, dbz_q, dbz_d;
  logic              out_valid_q, out_valid_d;
  logic signed [OUT_W-1:0] out_ratio_q, out_ratio_d;
  logic              out_dbz_q, out_dbz_d;

  logic [SW:0]       sum_add;
  logic [SW-1:0]     bsum_eff, s_ab, s_ba, smag;
  logic [CW-1:0]     bcnt_eff, c_ab, c_ba, cmag;
  logic              sneg, cneg;
  logic [CW:0]       trial;
  logic              ge;
  logic [QEXT_W-1:0] q_ext, q_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_ticks_q <= WINDOW_TICKS_RST;
      min_capture_q  <= MIN_CAPTURE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_WINDOW_TICKS: window_ticks_q <= cfg_data_i;
        REG_MIN_CAPTURE:  min_capture_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign sts_o.close    = (evt_func_i == FUNC_TICK) && (tick_q == window_ticks_q);
  assign sts_o.div_last = (step_q == STEP_W'(NUM_W - 1));
  assign sts_o.out_free = !out_valid_q || res_ready_i;

  assign sum_add  = {1'b0, sum_q} + (SW+1)'(evt_capture_value_i);
  assign bsum_eff = evt_calibrate_request_i ? sum_q : base_sum_q;
  assign bcnt_eff = evt_calibrate_request_i ? count_q : base_count_q;
  assign s_ab     = sum_q - bsum_eff;
  assign s_ba     = bsum_eff - sum_q;
  assign sneg     = sum_q < bsum_eff;
  assign smag     = sneg ? s_ba : s_ab;
  assign c_ab     = count_q - bcnt_eff;
  assign c_ba     = bcnt_eff - count_q;
  assign cneg     = count_q < bcnt_eff;
  assign cmag     = cneg ? c_ba : c_ab;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  assign q_ext = QEXT_W'(num_q);

  always_comb begin
    count_d      = count_q;
    sum_d        = sum_q;
    base_count_d = base_count_q;
    base_sum_d   = base_sum_q;
    tick_d       = tick_q;
    num_d        = num_q;
    den_d        = den_q;
    rem_d        = rem_q;
    step_d       = step_q;
    neg_d        = neg_q;
    dbz_d        = dbz_q;
    if (cmd_i.accept) begin
      if (evt_func_i == FUNC_CAPTURE) begin
        if (evt_capture_value_i > min_capture_q) begin
          if (count_q != '1) begin
            count_d = count_q + 1'b1;
          end
          sum_d = sum_add[SW] ? '1 : sum_add[SW-1:0];
        end
      end else if (!sts_o.close) begin
        tick_d = tick_q + 1'b1;
      end else begin
        if (evt_calibrate_request_i) begin
          base_count_d = count_q;
          base_sum_d   = sum_q;
        end
        num_d   = NUM_W'(smag) << FRAC_BITS;
        den_d   = cmag;
        rem_d   = '0;
        step_d  = '0;
        neg_d   = sneg ^ cneg;
        dbz_d   = (cmag == '0);
        count_d = '0;
        sum_d   = '0;
        tick_d  = '0;
      end
    end else if (cmd_i.div_step) begin
      rem_d  = ge ? CW'(trial - {1'b0, den_q}) : trial[CW-1:0];
      num_d  = {num_q[NUM_W-2:0], ge};
      step_d = step_q + 1'b1;
    end
  end

  always_comb begin
    q_sat = '0;
    if (neg_q && q_ext != '0) begin
      q_sat = (q_ext > NEG_MAX) ? NEG_MAX : q_ext;
    end else begin
      q_sat = (q_ext > POS_MAX) ? POS_MAX : q_ext;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_ratio_d = out_ratio_q;
    out_dbz_d   = out_dbz_q;
    if (cmd_i.load) begin
      out_valid_d = 1'b1;
      out_dbz_d   = dbz_q;
      if (dbz_q) begin
        out_ratio_d = '0;
      end else if (neg_q) begin
        out_ratio_d = OUT_W'(-q_sat);
      end else begin
        out_ratio_d = OUT_W'(q_sat);
      end
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      sum_q        <= '0;
      base_count_q <= CW'(BASE_COUNT_RST);
      base_sum_q   <= SW'(BASE_SUM_RST);
      tick_q       <= '0;
      step_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q      <= count_d;
      sum_q        <= sum_d;
      base_count_q <= base_count_d;
      base_sum_q   <= base_sum_d;
      tick_q       <= tick_d;
      step_q       <= step_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q       <= num_d;
    den_q       <= den_d;
    rem_q       <= rem_d;
    neg_q       <= neg_d;
    dbz_q       <= dbz_d;
    out_ratio_q <= out_ratio_d;
    out_dbz_q   <= out_dbz_d;
  end

  assign res_valid_o          = out_valid_q;
  assign res_ratio_value_o    = out_ratio_q;
  assign res_divide_by_zero_o = out_dbz_q;

  `GPAM_ASSERT(a_valid_from_load, $rose(out_valid_q) |-> $past(cmd_i.load), "result shown without a load")
  `GPAM_ASSERT(a_dbz_zero, (out_valid_q && out_dbz_q) |-> (out_ratio_q == '0), "zero divisor with nonzero ratio")
  `GPAM_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_q, "result valid in reset")

endmodule

`default_nettype wire

// ===== rtl/gated_period_average_meter_unit.sv =====
`default_nettype none

// Gated period average meter. Capture words (func 0) above min_capture add to
// a saturating count and period sum; gate ticks (func 1) advance the window,
// and the tick after window_ticks ticks closes it and yields one result:
// (sum - baseline sum) * 2^FRAC_BITS / (count - baseline count), signed,
// saturated to 40 bits, or a divide-by-zero flag. Capture words and ticks that
// do not close the window are taken back to back. A closing tick starts the
// restoring divider, which retires one quotient bit per cycle, and the input
// stays held off until the result sits in the output register. If that
// register is still full, the block waits for it to drain. Configuration
// writes are taken every cycle.
module gated_period_average_meter_unit import gpam_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned SUM_WIDTH   = 32,
  parameter int unsigned FRAC_BITS   = 8
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  gpam_evt_if.sink     evt_i,
  gpam_cfg_if.sink     cfg_i,
  gpam_res_if.source   res_o
);

  gpam_cmd_t cmd;
  gpam_sts_t sts;
  logic      evt_ready;

  assign evt_i.ready = evt_ready;
  assign cfg_i.ready = 1'b1;

  gpam_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_valid_i (evt_i.valid),
    .evt_ready_o (evt_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gpam_dp #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .SUM_WIDTH   (SUM_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cmd_i                   (cmd),
    .sts_o                   (sts),
    .evt_func_i              (evt_i.func),
    .evt_capture_value_i     (evt_i.capture_value),
    .evt_calibrate_request_i (evt_i.calibrate_request),
    .cfg_we_i                (cfg_i.valid),
    .cfg_index_i             (cfg_i.index),
    .cfg_data_i              (cfg_i.data),
    .res_valid_o             (res_o.valid),
    .res_ready_i             (res_o.ready),
    .res_ratio_value_o       (res_o.ratio_value),
    .res_divide_by_zero_o    (res_o.divide_by_zero)
  );

endmodule

`default_nettype wire
